>>> hw/rtl/tswa_pkg.sv
// Shared types, constants and state encodings for the temperature window average block.
package tswa_pkg;

    localparam int MAX_WINDOW_DEFAULT = 16;
    localparam int MAX_WINDOW_LIMIT   = 64;

    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd3;

    localparam int BYTE_W      = 8;
    localparam int STATUS_BITS = 3;
    localparam int RAW_W       = 2 * BYTE_W - STATUS_BITS;
    localparam int TENTHS_W    = 13;
    localparam int DEGREES_W   = 9;
    localparam int DIGIT_W     = 4;

    // Command fields are sized for the largest supported window.
    localparam int CMD_SLOT_W  = $clog2(MAX_WINDOW_LIMIT);
    localparam int CMD_WIN_W   = $clog2(MAX_WINDOW_LIMIT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // floor(x * 6554 / 2^16) equals floor(x / 10) for every x below 5120.
    localparam int RECIP_SHIFT = 16;
    localparam logic [TENTHS_W-1:0] RECIP10 = 13'd6554;
    localparam int PROD_W      = 2 * TENTHS_W;

    typedef struct packed {
        logic [BYTE_W-1:0] high_byte;
        logic [BYTE_W-1:0] low_byte;
    } t_in_word;

    typedef struct packed {
        logic [TENTHS_W-1:0]  average_tenths;
        logic [DEGREES_W-1:0] whole_degrees;
        logic [DIGIT_W-1:0]   tenths_digit;
    } t_out_word;

    typedef struct packed {
        logic [TENTHS_W-1:0]   tenths;
        logic [CMD_SLOT_W-1:0] slot;
        logic [CMD_WIN_W-1:0]  window;
        logic                  emit;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_DIV,
        BK_DIGITS
    } t_back_state;

endpackage

>>> hw/rtl/tswa_front.sv
// Front end: accepts readings, converts to tenths, tracks write slot and fill state.
module tswa_front #(
    parameter int MAX_WINDOW = tswa_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tswa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tswa_pkg::t_in_word         i_in_word,
    input  logic                       i_q_full,
    output logic                       o_push,
    output tswa_pkg::t_cmd             o_cmd
);
    import tswa_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0]  r_window_length;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_filled;
    logic              n_filled;

    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  slot_inc;
    logic [RAW_W-1:0]  raw;
    logic [15:0]       raw_x5;
    logic              wrap;
    logic              accept;

    // Zero acts as one, anything above the store depth as the full depth.
    always_comb begin
        if (r_window_length == '0) begin
            win = WIN_W'(1);
        end else if (32'(r_window_length) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = WIN_W'(r_window_length);
        end
    end

    assign raw      = {i_in_word.high_byte, i_in_word.low_byte[BYTE_W-1:STATUS_BITS]};
    assign raw_x5   = 16'({raw, 2'b00}) + 16'(raw);
    assign slot_inc = WIN_W'(r_slot) + WIN_W'(1);
    assign wrap     = (slot_inc >= win);

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_cmd.tenths = raw_x5[15:3];
        o_cmd.slot   = CMD_SLOT_W'(r_slot);
        o_cmd.window = CMD_WIN_W'(win);
        o_cmd.emit   = r_filled || wrap;
    end

    always_comb begin
        n_slot   = r_slot;
        n_filled = r_filled;
        if (accept) begin
            if (wrap) begin
                n_slot   = '0;
                n_filled = 1'b1;
            end else begin
                n_slot = slot_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
            r_slot          <= '0;
            r_filled        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_length <= i_cfg_wdata;
            end
            r_slot   <= n_slot;
            r_filled <= n_filled;
        end
    end

endmodule

>>> hw/rtl/tswa_queue.sv
// Short command queue between the front end and the averaging back end.
module tswa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tswa_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tswa_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import tswa_pkg::*;

    t_cmd                 r_slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/tswa_back.sv
// Back end: sample store, windowed sum, serial divide, digit split and output register.
module tswa_back #(
    parameter int MAX_WINDOW = tswa_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tswa_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tswa_pkg::t_out_word o_out_word
);
    import tswa_pkg::*;

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = TENTHS_W + $clog2(MAX_WINDOW);
    localparam int STEP_W = $clog2(SUM_W + 1);

    // Sample store; an entry not yet written reads as zero.
    logic [TENTHS_W-1:0]   r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_valid_bits;
    logic [TENTHS_W-1:0]   r_rd_data;
    logic                  r_rd_vld;

    t_back_state        r_state, n_state;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [WIN_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_acc, n_acc;
    logic [WIN_W-1:0]   r_rem, n_rem;
    logic [SUM_W-1:0]   r_quo, n_quo;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [WIN_W:0]     trial;
    logic [WIN_W:0]     trial_diff;
    logic [TENTHS_W-1:0] avg;
    logic [PROD_W-1:0]  prod;
    logic [DEGREES_W-1:0] whole;
    logic [TENTHS_W-1:0] whole_x10;
    logic [TENTHS_W-1:0] digit_full;

    assign wr_en   = (r_state == BK_IDLE) && i_cmd_valid;
    assign wr_addr = i_cmd.slot[SLOT_W-1:0];
    assign rd_en   = (r_state == BK_SUM) && (r_cnt < r_win);
    assign rd_addr = r_cnt[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.tenths;
        end
        if (rd_en) begin
            r_rd_data <= r_valid_bits[rd_addr] ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid_bits[wr_addr] <= 1'b1;
            end
            r_rd_vld <= rd_en;
        end
    end

    // One restoring divide step per cycle.
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_win};

    assign avg        = r_quo[TENTHS_W-1:0];
    assign prod       = PROD_W'(avg) * PROD_W'(RECIP10);
    assign whole      = prod[RECIP_SHIFT +: DEGREES_W];
    assign whole_x10  = TENTHS_W'({whole, 3'b000}) + TENTHS_W'({whole, 1'b0});
    assign digit_full = avg - whole_x10;

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_cmd_pop   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid && i_cmd.emit) begin
                    n_win   = i_cmd.window[WIN_W-1:0];
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                if (rd_en) begin
                    n_cnt = r_cnt + WIN_W'(1);
                end
                if (r_rd_vld) begin
                    n_acc = r_acc + SUM_W'(r_rd_data);
                end
                if ((r_cnt == r_win) && !r_rd_vld) begin
                    n_quo   = r_acc;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (!trial_diff[WIN_W]) begin
                    n_rem = trial_diff[WIN_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[WIN_W-1:0];
                    n_quo = {r_quo[SUM_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = BK_DIGITS;
                end
            end
            BK_DIGITS: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid               = 1'b1;
                    n_out_word.average_tenths = avg;
                    n_out_word.whole_degrees  = whole;
                    n_out_word.tenths_digit   = digit_full[DIGIT_W-1:0];
                    n_state                   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_digits_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (TENTHS_W'(r_out_word.whole_degrees) * TENTHS_W'(10)
                         + TENTHS_W'(r_out_word.tenths_digit)) == r_out_word.average_tenths)
        else $error("whole degrees and tenths digit do not rebuild the average");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.average_tenths <= TENTHS_W'(5119)))
        else $error("average above the largest reading");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SUM) |-> (r_cnt <= r_win))
        else $error("store read beyond the window");

    a_load_from_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == BK_DIGITS))
        else $error("result loaded outside the digit step");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !wr_en)
        else $error("store written while a window sum is in progress");

endmodule

>>> hw/rtl/temp_sensor_window_average.sv
// Moving average of two-byte temperature readings in tenths of a degree. Each accepted word
// is converted and queued (two deep); the back end takes it from the queue when idle and
// stores it as it takes it. Once the window has filled, each reading also yields a result:
// the sum reads one store entry per cycle and then drains the read register, and the
// divider retires one quotient bit per cycle. Readings before the window fills are only
// stored and give no result. The store needs no clearing pass after reset: per-entry valid
// bits make it read as zero.
module temp_sensor_window_average #(
    parameter int MAX_WINDOW = tswa_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tswa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tswa_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tswa_pkg::t_out_word        o_out_word
);
    import tswa_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    tswa_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    tswa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd),
        .i_pop   (q_pop)
    );

    tswa_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

>>> tb/tswa_average_checker.sv
// Watches the temperature window average channels, predicts each average and compares.
module tswa_average_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tswa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  tswa_pkg::t_in_word         i_in_word,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  tswa_pkg::t_out_word        i_out_word,
    input  logic                       i_end_check,
    output int                         o_pending,
    output int                         o_results,
    output int                         o_errors
);
    import tswa_pkg::*;

    localparam int DEPTH = MAX_WINDOW_DEFAULT;

    logic [CFG_W-1:0]    window_reg;
    logic [TENTHS_W-1:0] samples [DEPTH];
    int unsigned         slot;
    bit                  filled;
    bit                  end_seen = 1'b0;
    int                  results = 0;
    int                  errors = 0;
    t_out_word           pending_averages [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Store one reading and queue the average it yields once the window has filled.
    task automatic average_reading(input t_in_word w);
        int unsigned span;
        int unsigned raw;
        int unsigned tenths;
        int unsigned total;
        int unsigned avg;
        int unsigned deg;
        int unsigned dig;
        t_out_word   want;
        span = 32'(window_reg);
        if (span == 0) span = 1;
        if (span > DEPTH) span = DEPTH;
        raw    = 32'({w.high_byte, w.low_byte});
        raw    = raw >> STATUS_BITS;
        tenths = (raw * 5) >> 3;
        samples[slot] = tenths[TENTHS_W-1:0];
        slot++;
        // Wrap also covers a window shrunk below the current slot.
        if (slot >= span) begin
            filled = 1'b1;
            slot   = 0;
        end
        if (!filled) return;
        total = 0;
        for (int k = 0; k < span; k++) total += 32'(samples[k]);
        avg = total / span;
        deg = avg / 10;
        dig = avg % 10;
        want.average_tenths = avg[TENTHS_W-1:0];
        want.whole_degrees  = deg[DEGREES_W-1:0];
        want.tenths_digit   = dig[DIGIT_W-1:0];
        pending_averages.push_back(want);
    endtask

    task automatic check_average(input t_out_word got);
        t_out_word want;
        results++;
        if (pending_averages.size() == 0) begin
            report_mismatch("average with none pending", int'(got.average_tenths), -1);
            return;
        end
        want = pending_averages.pop_front();
        if (got.average_tenths !== want.average_tenths)
            report_mismatch("average_tenths", int'(got.average_tenths),
                            int'(want.average_tenths));
        if (got.whole_degrees !== want.whole_degrees)
            report_mismatch("whole_degrees", int'(got.whole_degrees),
                            int'(want.whole_degrees));
        if (got.tenths_digit !== want.tenths_digit)
            report_mismatch("tenths_digit", int'(got.tenths_digit), int'(want.tenths_digit));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_reg = WINDOW_RESET;
            for (int k = 0; k < DEPTH; k++) samples[k] = '0;
            slot   = 0;
            filled = 1'b0;
            pending_averages.delete();
        end else begin
            if (i_cfg_we) window_reg = i_cfg_wdata;
            // Retire the output first so a word accepted this edge never matches itself.
            if (i_out_valid && i_out_ready) check_average(i_out_word);
            if (i_in_valid && i_in_ready) average_reading(i_in_word);
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (pending_averages.size() != 0)
                    report_mismatch("averages never delivered", pending_averages.size(), 0);
            end
        end
        o_pending <= pending_averages.size();
        o_results <= results;
        o_errors  <= errors;
    end

endmodule

>>> tb/tb.sv
// Stimulus, clock, reset and verdict for the temperature window average block.
module tb;
    import tswa_pkg::*;

    localparam int PERIOD        = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 60;
    localparam int LIMIT_CYCLES  = 800000;
    localparam int IDLE_PCT      = 14;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    t_in_word         in_word;
    logic             out_valid;
    logic             out_ready;
    t_out_word        out_word;
    logic             end_check;
    int               pending;
    int               results;
    int               errors;
    int unsigned      cycles = 0;
    int               sent = 0;
    int               windows_set = 0;
    bit               idle_on = 1'b1;
    bit               hold_done = 1'b0;

    temp_sensor_window_average uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    tswa_average_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .i_end_check (end_check),
        .o_pending   (pending),
        .o_results   (results),
        .o_errors    (errors)
    );

    initial begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d averages still pending", cycles, pending);
            $display("temp_sensor_window_average test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up its input.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && results >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    function automatic logic [CFG_W-1:0] window_for_phase(input int p);
        case (p)
            0:       return 5'd1;
            1:       return 5'd16;
            2:       return 5'd0;
            3:       return 5'd31;
            4:       return 5'd7;
            5:       return 5'd3;
            6:       return 5'd17;
            7:       return 5'd12;
            8:       return 5'd2;
            9:       return 5'd16;
            10:      return 5'd5;
            default: return 5'd9;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [7:0] hi, input logic [7:0] lo);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_word.high_byte <= hi;
        in_word.low_byte  <= lo;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every average has come out and the back end has gone quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_window(input logic [CFG_W-1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        windows_set++;
        @(negedge clk);
    endtask

    initial begin
        logic [7:0] hi;
        logic [7:0] lo;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        end_check = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset window of three: the first two readings give nothing.
        send_word(8'h00, 8'h00);
        send_word(8'hFF, 8'hFF);
        send_word(8'hFF, 8'hF8);
        send_word(8'h80, 8'h07);
        send_word(8'h00, 8'h07);
        load_window(5'd1);
        send_word(8'hFF, 8'hFF);
        send_word(8'h00, 8'h00);
        send_word(8'h12, 8'h34);
        // Zero acts as a window of one.
        load_window(5'd0);
        send_word(8'hAB, 8'hCD);
        send_word(8'h7F, 8'hFF);
        // Oversize clamps to the store depth; stale entries are averaged as they are.
        load_window(5'd31);
        send_word(8'hFF, 8'hFF);
        send_word(8'h01, 8'h00);
        send_word(8'h55, 8'hAA);
        load_window(5'd16);
        for (int k = 0; k < 5; k++) send_word(8'(8'h33 * k), 8'(8'hC3 ^ (8'h11 * k)));
        // Shrink below the write slot: the word still lands there, then wraps.
        load_window(5'd2);
        send_word(8'hFF, 8'hFF);
        send_word(8'h00, 8'h08);

        for (int p = 0; p < PHASES; p++) begin
            load_window(window_for_phase(p));
            idle_on = !(p == 4 || p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 7 && k == PHASE_ITEMS / 2) wait_drained();
                case ($urandom_range(9))
                    0: begin
                        hi = 8'h00;
                        lo = 8'h00;
                    end
                    1: begin
                        hi = 8'hFF;
                        lo = 8'hFF;
                    end
                    2: begin
                        hi = 8'($urandom_range(255));
                        lo = {5'h1F, 3'($urandom_range(7))};
                    end
                    default: begin
                        hi = 8'($urandom_range(255));
                        lo = 8'($urandom_range(255));
                    end
                endcase
                send_word(hi, lo);
            end
        end

        idle_on = 1'b1;
        wait_drained();
        end_check <= 1'b1;
        repeat (2) @(negedge clk);
        $display("Sent %0d readings over %0d window writes (0, 1, 16 and oversize among them),",
                 sent, windows_set);
        $display("checked %0d averages under random stalls and one long output hold-off.",
                 results);
        if (errors == 0) begin
            $display("temp_sensor_window_average test passed");
        end else begin
            $display("temp_sensor_window_average test failed");
        end
        $finish;
    end

endmodule
